FILE: design/sequential_list_engine_top_defines.svh
// Assertion helpers used by the list engine controller (lst_ctrl).
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define LST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define LST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lst_pkg.sv
`timescale 1ns / 1ps

package lst_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_DELETE = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ILLEGAL  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_IDX_DN = 2'd1,
    RD_IDX_UP = 2'd2
  } rd_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    latch;
    logic    idx_ld_count;
    logic    idx_ld_zero;
    logic    idx_ld_pos;
    logic    idx_inc;
    logic    idx_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_value;
    logic    wr_at_pos;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    set_status;
    status_t status;
    logic    set_where;
    logic    push;
  } lst_cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    pos_gt_count;
    logic    pos_ge_count;
    logic    idx_gt_pos;
    logic    idx_up_lt_count;
    logic    idx_lt_count;
    logic    match;
    logic    out_free;
  } lst_sts_t;

endpackage

FILE: design/lst_req_if.sv
`timescale 1ns / 1ps

interface lst_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;
  logic [7:0]         position;

  modport source (output valid, output action, output value, output position, input ready);
  modport sink (input valid, input action, input value, input position, output ready);
endinterface

FILE: design/lst_rsp_if.sv
`timescale 1ns / 1ps

interface lst_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [2:0] found_position;
  logic [3:0] entry_count;

  modport source (output valid, output status, output found_position, output entry_count,
                  input ready);
  modport sink (input valid, input status, input found_position, input entry_count,
                output ready);
endinterface

FILE: design/lst_ram.sv
`timescale 1ns / 1ps

module lst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lst_datapath.sv
`timescale 1ns / 1ps

module lst_datapath
  import lst_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_value,
  input  logic [7:0]         in_position,
  lst_rsp_if.source          out_rsp,
  input  lst_cmd_t           cmd,
  output lst_sts_t           sts
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  logic [1:0]         action_r;
  logic signed [31:0] value_r;
  logic [7:0]         pos_r;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  status_t            status_r;
  logic [2:0]         where_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [2:0]         out_where_r;
  logic [3:0]         out_count_r;

  logic [XW-1:0] pos_x, cnt_x, idx_x, rd_x;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   rd_data, wr_data;

  assign pos_x = XW'(pos_r);
  assign cnt_x = XW'(count_r);
  assign idx_x = XW'(idx_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX_DN: rd_x = idx_x - XW'(1);
      RD_IDX_UP: rd_x = idx_x + XW'(1);
      default:   rd_x = idx_x;
    endcase
  end

  assign raddr   = rd_x[AW-1:0];
  assign waddr   = cmd.wr_at_pos ? pos_x[AW-1:0] : idx_x[AW-1:0];
  assign wr_data = cmd.wr_value ? $unsigned(value_r) : rd_data;

  lst_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_ld_count) begin
      idx_nxt = count_r;
    end else if (cmd.idx_ld_zero) begin
      idx_nxt = '0;
    end else if (cmd.idx_ld_pos) begin
      idx_nxt = pos_x[CW-1:0];
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + CW'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_r - CW'(1);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.latch) begin
      action_r <= in_action;
      value_r  <= in_value;
      pos_r    <= in_position;
      where_r  <= '0;
    end else if (cmd.set_where) begin
      where_r <= idx_x[2:0];
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.push) begin
      out_status_r <= status_r;
      out_where_r  <= where_r;
      out_count_r  <= cnt_x[3:0];
    end
  end

  assign sts.action          = action_t'(action_r);
  assign sts.full            = (count_r == CW'(CAPACITY));
  assign sts.pos_gt_count    = (pos_x > cnt_x);
  assign sts.pos_ge_count    = (pos_x >= cnt_x);
  assign sts.idx_gt_pos      = (idx_x > pos_x);
  assign sts.idx_up_lt_count = ((idx_x + XW'(1)) < cnt_x);
  assign sts.idx_lt_count    = (idx_r < count_r);
  assign sts.match           = (rd_data == $unsigned(value_r));
  assign sts.out_free        = !out_valid_r || out_rsp.ready;

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.status         = out_status_r;
  assign out_rsp.found_position = out_where_r;
  assign out_rsp.entry_count    = out_count_r;

endmodule

FILE: design/lst_ctrl.sv
`timescale 1ns / 1ps
`include "sequential_list_engine_top_defines.svh"

module lst_ctrl
  import lst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  lst_sts_t sts,
  output lst_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   find_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        case (sts.action)
          ACT_INSERT: begin
            state_nxt = (sts.full || sts.pos_gt_count) ? S_DONE : S_INS_RD;
          end
          ACT_FIND:   state_nxt = S_FIND_RD;
          ACT_DELETE: state_nxt = sts.pos_ge_count ? S_DONE : S_DEL_RD;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_INS_RD:   state_nxt = sts.idx_gt_pos ? S_INS_WR : S_DONE;
      S_INS_WR:   state_nxt = S_INS_RD;
      S_DEL_RD:   state_nxt = sts.idx_up_lt_count ? S_DEL_WR : S_DONE;
      S_DEL_WR:   state_nxt = S_DEL_RD;
      S_FIND_RD:  state_nxt = sts.idx_lt_count ? S_FIND_CMP : S_DONE;
      S_FIND_CMP: state_nxt = sts.match ? S_DONE : S_FIND_RD;
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_CHECK: begin
        case (sts.action)
          ACT_INSERT: begin
            if (sts.full) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
            end else if (sts.pos_gt_count) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_ILLEGAL;
            end else begin
              cmd.idx_ld_count = 1'b1;
            end
          end
          ACT_FIND: begin
            cmd.idx_ld_zero = 1'b1;
          end
          ACT_DELETE: begin
            if (sts.pos_ge_count) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_ILLEGAL;
            end else begin
              cmd.idx_ld_pos = 1'b1;
            end
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_ILLEGAL;
          end
        endcase
      end
      S_INS_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_DN;
        end else begin
          cmd.wr_en      = 1'b1;
          cmd.wr_value   = 1'b1;
          cmd.wr_at_pos  = 1'b1;
          cmd.cnt_inc    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
        end
      end
      S_INS_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_dec = 1'b1;
      end
      S_DEL_RD: begin
        if (sts.idx_up_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_UP;
        end else begin
          cmd.cnt_dec    = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
        end
      end
      S_DEL_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      S_FIND_RD: begin
        if (sts.idx_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOTFOUND;
        end
      end
      S_FIND_CMP: begin
        if (sts.match) begin
          cmd.set_where  = 1'b1;
          cmd.set_status = 1'b1;
          cmd.status     = ST_OK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_DONE: begin
        cmd.push = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign find_hit = (state_r == S_FIND_CMP) && sts.match;

  `LST_ASSERT_NXT(a_accept_to_check, in_valid && in_ready, state_r == S_CHECK, "start missed")
  `LST_ASSERT_IMP(a_push_slot_free, cmd.push, sts.out_free, "result pushed over a pending word")
  `LST_ASSERT_IMP(a_single_ram_op, cmd.wr_en, !cmd.rd_en, "read and write issued together")
  `LST_ASSERT_IMP(a_no_grow_when_full, cmd.cnt_inc, !sts.full, "count grew past capacity")
  `LST_ASSERT_NXT(a_hit_ends_find, find_hit, state_r == S_DONE, "find hit did not finish")

endmodule

FILE: design/sequential_list_engine_top.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a two-port RAM.
// in_req carries one request word (action, value, position); out_rsp returns one
// word per request with status, found_position and entry_count after the request.
// Requests are taken one at a time: in_req.ready is high only while the engine is
// idle. Entries are moved one at a time, each read from the RAM and then written
// back one slot over, which sets how long each request occupies the engine
// (p = position, c = count before): a rejected request (full, illegal position,
// unused action) moves none, an insert moves c-p entries up, a delete moves
// c-p-1 entries down, and a find reads entries from index 0 until a match or c.
// The result goes to out_rsp from S_DONE once the output slot is free.
// A registered output slot holds the result; the engine accepts the next request
// while that word still waits, and stalls before publishing another result until
// out_rsp.ready takes the pending word.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// the RAM contents are not cleared, entries past the count are never read.
`timescale 1ns / 1ps

module sequential_list_engine_top
  import lst_pkg::*;
#(
  parameter int CAPACITY = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  lst_req_if.sink   in_req,
  lst_rsp_if.source out_rsp
);

  lst_cmd_t cmd;
  lst_sts_t sts;
  logic     ctrl_ready;

  lst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (ctrl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_action   (in_req.action),
    .in_value    (in_req.value),
    .in_position (in_req.position),
    .out_rsp     (out_rsp),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign in_req.ready = ctrl_ready;

endmodule

FILE: verif/sequential_list_engine_top_tb.sv
`timescale 1ns / 1ps

module sequential_list_engine_top_tb;
  import lst_pkg::*;

  localparam int          CAP        = 8;
  localparam int          IDLE_LIMIT = 2000;
  localparam int          RAND_WORDS = 1750;
  localparam logic [1:0]  ACT_UNUSED = 2'd3;

  typedef struct {
    status_t    status;
    logic [2:0] where;
    logic [3:0] count;
  } list_rsp_t;

  class list_scoreboard;
    logic signed [31:0] slots [CAP];
    int unsigned        held;
    list_rsp_t          awaited [$];
    int unsigned        errors;
    int unsigned        seen [4];

    function new();
      held   = 0;
      errors = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void note_request(logic [1:0] act, logic signed [31:0] val, logic [7:0] pos);
      list_rsp_t   w;
      int unsigned i;
      w.status = ST_ILLEGAL;
      w.where  = '0;
      case (act)
        ACT_INSERT: begin
          if (held >= CAP) begin
            w.status = ST_FULL;
          end else if (pos <= held) begin
            for (i = held; i > pos; i--) slots[i] = slots[i - 1];
            slots[pos] = val;
            held++;
            w.status = ST_OK;
          end
        end
        ACT_FIND: begin
          w.status = ST_NOTFOUND;
          for (i = 0; i < held; i++) begin
            if (w.status == ST_NOTFOUND && slots[i] == val) begin
              w.status = ST_OK;
              w.where  = i[2:0];
            end
          end
        end
        ACT_DELETE: begin
          if (pos < held) begin
            for (i = pos; i + 1 < held; i++) slots[i] = slots[i + 1];
            held--;
            w.status = ST_OK;
          end
        end
        default: ;
      endcase
      w.count = held[3:0];
      awaited.push_back(w);
    endfunction

    function void check_result(logic [1:0] st, logic [2:0] where, logic [3:0] cnt);
      list_rsp_t w;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected word status=%0d found_position=%0d entry_count=%0d",
                 $time, st, where, cnt);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (st !== 2'bxx) seen[st]++;
      if (st !== w.status) begin
        $display("%0t: status expected %0d actual %0d", $time, w.status, st);
        errors++;
      end
      if (where !== w.where) begin
        $display("%0t: found_position expected %0d actual %0d", $time, w.where, where);
        errors++;
      end
      if (cnt !== w.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, w.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  bit             quiet;
  int unsigned    sent;
  list_scoreboard sb;

  lst_req_if req_if ();
  lst_rsp_if rsp_if ();

  sequential_list_engine_top #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3, 4: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] act, input logic signed [31:0] val,
                           input logic [7:0] pos);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.value    <= val;
    req_if.position <= pos;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(act, val, pos);
    sent++;
  endtask

  initial begin
    int stall;
    stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.status, rsp_if.found_position, rsp_if.entry_count);
      if (stall == 0) stall = gap_len();
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        stall--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          n;
    int          r;
    int          ins_pct;
    int unsigned held;
    logic [7:0]  pos;
    logic signed [31:0] val;

    sb    = new();
    sent  = 0;
    quiet = 1'b0;
    rst_n           <= 1'b0;
    req_if.valid    <= 1'b0;
    req_if.action   <= ACT_INSERT;
    req_if.value    <= '0;
    req_if.position <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(ACT_FIND,   32'sd0,            8'd0);
    send_word(ACT_DELETE, 32'sd0,            8'd0);
    send_word(ACT_INSERT, 32'sd4,            8'd1);
    send_word(ACT_INSERT, 32'sh8000_0000,    8'd0);
    send_word(ACT_INSERT, 32'sh7fff_ffff,    8'd1);
    send_word(ACT_INSERT, -32'sd1,           8'd0);
    send_word(ACT_INSERT, 32'sd0,            8'd1);
    send_word(ACT_UNUSED, 32'sh7fff_ffff,    8'd255);
    send_word(ACT_INSERT, 32'sd5,            8'd4);
    send_word(ACT_INSERT, 32'sd5,            8'd2);
    send_word(ACT_INSERT, 32'sd7,            8'd6);
    send_word(ACT_INSERT, 32'sd9,            8'd7);
    send_word(ACT_INSERT, 32'sd1,            8'd255);
    send_word(ACT_INSERT, 32'sd1,            8'd0);
    send_word(ACT_FIND,   32'sd5,            8'd0);
    send_word(ACT_FIND,   32'sd9,            8'd0);
    send_word(ACT_FIND,   32'sd12345,        8'd0);
    send_word(ACT_FIND,   32'sh8000_0000,    8'd0);
    send_word(ACT_DELETE, 32'sd0,            8'd8);
    send_word(ACT_DELETE, 32'sd0,            8'd255);
    send_word(ACT_DELETE, 32'sd0,            8'd7);
    send_word(ACT_DELETE, 32'sd0,            8'd0);
    send_word(ACT_DELETE, 32'sd0,            8'd3);
    send_word(ACT_FIND,   32'sd9,            8'd0);

    for (n = 0; n < RAND_WORDS; n++) begin
      if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      held    = sb.held;
      ins_pct = (held >= CAP - 1) ? 25 : ((held <= 1) ? 55 : 40);
      r       = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(ACT_UNUSED, $urandom, $urandom_range(0, 255));
      end else if (r < 3 + ins_pct) begin
        pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, held);
        send_word(ACT_INSERT, pick_value(), pos);
      end else if (r < 28 + ins_pct) begin
        if (held == 0 || $urandom_range(0, 9) == 0)
          pos = $urandom_range(0, 255);
        else
          pos = $urandom_range(0, held - 1);
        send_word(ACT_DELETE, $urandom, pos);
      end else begin
        if (held > 0 && $urandom_range(0, 9) < 7)
          val = sb.slots[$urandom_range(0, held - 1)];
        else
          val = pick_value();
        send_word(ACT_FIND, val, $urandom_range(0, 255));
      end
    end
    req_if.valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d requests on a list of %0d entries, random idling on both sides.",
             sent, CAP);
    $display("Results seen: %0d ok, %0d full, %0d illegal position, %0d not found.",
             sb.seen[ST_OK], sb.seen[ST_FULL], sb.seen[ST_ILLEGAL], sb.seen[ST_NOTFOUND]);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sequential_list_engine_top.f
+incdir+design
design/lst_pkg.sv
design/lst_req_if.sv
design/lst_rsp_if.sv
design/lst_ram.sv
design/lst_datapath.sv
design/lst_ctrl.sv
design/sequential_list_engine_top.sv
verif/sequential_list_engine_top_tb.sv
